### rtl/ppc_pkg.sv
package ppc_pkg;

    // widths fixed by the item formats
    localparam int COUNT_WIDTH = 24;
    localparam int OUT_WIDTH   = 24;
    localparam int SUM_WIDTH   = 26;
    localparam int PCT_WIDTH   = 7;
    localparam int INC_WIDTH   = 16;
    localparam int DEPTH_WIDTH = 24;
    localparam int BASE_WIDTH  = 4;
    localparam int PCT_SCALE   = 100;
    localparam int QUEUE_DEPTH = 2;

    // item kinds
    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // 4na base codes
    localparam logic [BASE_WIDTH-1:0] BASE_A = 4'h1;
    localparam logic [BASE_WIDTH-1:0] BASE_C = 4'h2;
    localparam logic [BASE_WIDTH-1:0] BASE_G = 4'h4;
    localparam logic [BASE_WIDTH-1:0] BASE_T = 4'h8;

    typedef struct packed {
        logic                   kind;
        logic                   invalid;
        logic                   skip;
        logic                   match;
        logic [BASE_WIDTH-1:0]  read_base;
        logic                   on_reverse;
        logic [INC_WIDTH-1:0]   inserted_count;
        logic [INC_WIDTH-1:0]   deleted_count;
        logic                   first_in_read;
        logic                   last_in_read;
        logic [DEPTH_WIDTH-1:0] depth;
    } t_in_item;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] match_total;
        logic [OUT_WIDTH-1:0] mismatch_a;
        logic [OUT_WIDTH-1:0] mismatch_c;
        logic [OUT_WIDTH-1:0] mismatch_g;
        logic [OUT_WIDTH-1:0] mismatch_t;
        logic [OUT_WIDTH-1:0] inserted_total;
        logic [OUT_WIDTH-1:0] deleted_total;
        logic [PCT_WIDTH-1:0] forward_percent;
        logic [OUT_WIDTH-1:0] starts_total;
        logic [OUT_WIDTH-1:0] ends_total;
        logic [SUM_WIDTH-1:0] mismatch_sum;
        logic                 report_flag;
    } t_out_item;

    // command classes passed from front to back
    typedef enum logic {
        OP_PLACE,
        OP_END
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic                   inc_match;
        logic [3:0]             inc_mis;
        logic                   on_reverse;
        logic [INC_WIDTH-1:0]   ins;
        logic [INC_WIDTH-1:0]   del;
        logic                   start;
        logic                   stop;
        logic [DEPTH_WIDTH-1:0] depth;
    } t_cmd;

endpackage

### rtl/ppc_chan_if.sv
interface ppc_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pileup_position_counter.sv
// placements: one request a cycle sustained unless an end waits at the queue head;
// counted after passing the queue. end of position: result from a snapshot, product
// stage, then a 7-step restoring divide for the forward percentage
// one end-of-position result is in flight at a time; placements keep counting
// meanwhile, and a following end waits until the pending result is taken
// reset (synchronous, active low) clears all counters, the queue and the threshold
module pileup_position_counter #(
    parameter int COUNT_WIDTH = ppc_pkg::COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppc_pkg::PCT_WIDTH-1:0] i_cfg_data,
    ppc_chan_if.sink                      i_in,
    ppc_chan_if.source                    o_out
);

    logic [ppc_pkg::PCT_WIDTH-1:0] r_min_pct;
    logic                          w_push;
    logic                          w_full;
    logic                          w_pop;
    logic                          w_empty;
    ppc_pkg::t_cmd                 w_push_cmd;
    ppc_pkg::t_cmd                 w_head_cmd;

    // threshold register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pct <= '0;
        end else if (i_cfg_we) begin
            r_min_pct <= i_cfg_data;
        end
    end

    ppc_front u_front (
        .i_in   (i_in),
        .i_full (w_full),
        .o_push (w_push),
        .o_cmd  (w_push_cmd)
    );

    ppc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_cmd   (w_head_cmd)
    );

    ppc_back #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (w_empty),
        .i_cmd     (w_head_cmd),
        .o_pop     (w_pop),
        .i_min_pct (r_min_pct),
        .o_out     (o_out)
    );

endmodule

### rtl/ppc_front.sv
module ppc_front (
    ppc_chan_if.sink        i_in,
    input  logic            i_full,
    output logic            o_push,
    output ppc_pkg::t_cmd   o_cmd
);

    ppc_pkg::t_in_item w_item;
    logic              w_counted;

    assign w_item     = i_in.payload;
    assign i_in.ready = !i_full;

    // invalid placements are taken and dropped here
    assign o_push = i_in.valid && !i_full &&
                    (w_item.kind == ppc_pkg::KIND_END || !w_item.invalid);

    assign w_counted = !w_item.skip;

    // classify the request into a back-end command
    always_comb begin
        o_cmd            = '0;
        o_cmd.op         = (w_item.kind == ppc_pkg::KIND_END) ? ppc_pkg::OP_END
                                                              : ppc_pkg::OP_PLACE;
        o_cmd.inc_match  = w_counted && w_item.match;
        o_cmd.on_reverse = w_item.on_reverse;
        o_cmd.ins        = w_item.inserted_count;
        o_cmd.del        = w_item.deleted_count;
        o_cmd.start      = w_item.first_in_read;
        o_cmd.stop       = w_item.last_in_read;
        o_cmd.depth      = w_item.depth;
        if (w_counted && !w_item.match) begin
            unique case (w_item.read_base)
                ppc_pkg::BASE_A: o_cmd.inc_mis = 4'b0001;
                ppc_pkg::BASE_C: o_cmd.inc_mis = 4'b0010;
                ppc_pkg::BASE_G: o_cmd.inc_mis = 4'b0100;
                ppc_pkg::BASE_T: o_cmd.inc_mis = 4'b1000;
                default:         o_cmd.inc_mis = 4'b0000;
            endcase
        end
    end

endmodule

### rtl/ppc_queue.sv
module ppc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ppc_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output ppc_pkg::t_cmd o_cmd
);

    localparam int AW = (ppc_pkg::QUEUE_DEPTH > 1) ? $clog2(ppc_pkg::QUEUE_DEPTH) : 1;

    ppc_pkg::t_cmd  r_mem [ppc_pkg::QUEUE_DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [AW:0]    r_count;
    logic           w_wr;
    logic           w_rd;

    assign o_full  = (r_count == (AW+1)'(ppc_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(ppc_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                       : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/ppc_back.sv
module ppc_back #(
    parameter int COUNT_WIDTH = ppc_pkg::COUNT_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  ppc_pkg::t_cmd                 i_cmd,
    output logic                          o_pop,
    input  logic [ppc_pkg::PCT_WIDTH-1:0] i_min_pct,
    ppc_chan_if.source                    o_out
);

    localparam int CW  = COUNT_WIDTH;
    localparam int SW  = ((CW > ppc_pkg::INC_WIDTH) ? CW : ppc_pkg::INC_WIDTH) + 1;
    localparam int MW  = CW + 2;
    localparam int DW  = CW + ppc_pkg::PCT_WIDTH;
    localparam int LW0 = MW + ppc_pkg::PCT_WIDTH;
    localparam int LW1 = ppc_pkg::PCT_WIDTH + ppc_pkg::DEPTH_WIDTH;
    localparam int LW  = (LW0 > LW1) ? LW0 : LW1;
    localparam int PW  = ppc_pkg::PCT_WIDTH;
    localparam int OW  = ppc_pkg::OUT_WIDTH;
    localparam int SPW = $clog2(PW);
    localparam logic [CW-1:0] CNT_MAX = '1;

    typedef enum logic [3:0] {
        E_IDLE = 4'b0001,
        E_PREP = 4'b0010,
        E_DIV  = 4'b0100,
        E_OUT  = 4'b1000
    } t_end_state;

    function automatic logic [CW-1:0] f_sat_add(
        input logic [CW-1:0]                 a,
        input logic [ppc_pkg::INC_WIDTH-1:0] b
    );
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        return (s > SW'(CNT_MAX)) ? CNT_MAX : CW'(s);
    endfunction

    // counters
    logic [CW-1:0] r_match, n_match;
    logic [CW-1:0] r_mis [4];
    logic [CW-1:0] n_mis [4];
    logic [CW-1:0] r_ins, n_ins;
    logic [CW-1:0] r_del, n_del;
    logic [CW-1:0] r_fwd, n_fwd;
    logic [CW-1:0] r_rev, n_rev;
    logic [CW-1:0] r_starts, n_starts;
    logic [CW-1:0] r_ends, n_ends;

    // end-of-position unit
    t_end_state                    r_state;
    ppc_pkg::t_out_item            r_res;
    logic [MW-1:0]                 r_msum;
    logic [CW-1:0]                 r_fwd_snap;
    logic [CW:0]                   r_den;
    logic [ppc_pkg::DEPTH_WIDTH-1:0] r_depth;
    logic [LW-1:0]                 r_lhs;
    logic [LW-1:0]                 r_rhs;
    logic [DW-1:0]                 r_rem;
    logic [DW-1:0]                 r_dsh;
    logic [PW-1:0]                 r_quo;
    logic [SPW-1:0]                r_step;

    logic          w_place;
    logic          w_end;
    logic [MW-1:0] w_msum;
    logic          w_fit;
    logic [PW-1:0] w_quo;

    // placements go every cycle, an end waits for the end unit
    assign o_pop   = !i_empty && (i_cmd.op == ppc_pkg::OP_PLACE || r_state == E_IDLE);
    assign w_place = o_pop && i_cmd.op == ppc_pkg::OP_PLACE;
    assign w_end   = o_pop && i_cmd.op == ppc_pkg::OP_END;

    assign w_msum = MW'(r_mis[0]) + MW'(r_mis[1]) + MW'(r_mis[2]) + MW'(r_mis[3]);

    // counter update
    always_comb begin
        n_match  = r_match;
        n_ins    = r_ins;
        n_del    = r_del;
        n_fwd    = r_fwd;
        n_rev    = r_rev;
        n_starts = r_starts;
        n_ends   = r_ends;
        for (int k = 0; k < 4; k++) begin
            n_mis[k] = r_mis[k];
        end
        if (w_end) begin
            n_match  = '0;
            n_ins    = '0;
            n_del    = '0;
            n_fwd    = '0;
            n_rev    = '0;
            n_starts = '0;
            n_ends   = '0;
            for (int k = 0; k < 4; k++) begin
                n_mis[k] = '0;
            end
        end else if (w_place) begin
            if (i_cmd.inc_match) begin
                n_match = f_sat_add(r_match, ppc_pkg::INC_WIDTH'(1));
            end
            for (int k = 0; k < 4; k++) begin
                if (i_cmd.inc_mis[k]) begin
                    n_mis[k] = f_sat_add(r_mis[k], ppc_pkg::INC_WIDTH'(1));
                end
            end
            if (i_cmd.on_reverse) begin
                n_rev = f_sat_add(r_rev, ppc_pkg::INC_WIDTH'(1));
            end else begin
                n_fwd = f_sat_add(r_fwd, ppc_pkg::INC_WIDTH'(1));
            end
            n_ins = f_sat_add(r_ins, i_cmd.ins);
            n_del = f_sat_add(r_del, i_cmd.del);
            if (i_cmd.start) begin
                n_starts = f_sat_add(r_starts, ppc_pkg::INC_WIDTH'(1));
            end
            if (i_cmd.stop) begin
                n_ends = f_sat_add(r_ends, ppc_pkg::INC_WIDTH'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match  <= '0;
            r_ins    <= '0;
            r_del    <= '0;
            r_fwd    <= '0;
            r_rev    <= '0;
            r_starts <= '0;
            r_ends   <= '0;
            for (int k = 0; k < 4; k++) begin
                r_mis[k] <= '0;
            end
        end else begin
            r_match  <= n_match;
            r_ins    <= n_ins;
            r_del    <= n_del;
            r_fwd    <= n_fwd;
            r_rev    <= n_rev;
            r_starts <= n_starts;
            r_ends   <= n_ends;
            for (int k = 0; k < 4; k++) begin
                r_mis[k] <= n_mis[k];
            end
        end
    end

    // one restoring divide step
    assign w_fit = (r_rem >= r_dsh);
    always_comb begin
        w_quo = r_quo;
        if (w_fit) begin
            w_quo[r_step] = 1'b1;
        end
    end

    // end unit state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= E_IDLE;
        end else begin
            unique case (r_state)
                E_IDLE: if (w_end) r_state <= E_PREP;
                E_PREP: r_state <= E_DIV;
                E_DIV:  if (r_step == '0) r_state <= E_OUT;
                E_OUT:  if (o_out.ready) r_state <= E_IDLE;
                default: r_state <= E_IDLE;
            endcase
        end
    end

    // end unit datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            E_IDLE: begin
                if (w_end) begin
                    r_res.match_total    <= OW'(r_match);
                    r_res.mismatch_a     <= OW'(r_mis[0]);
                    r_res.mismatch_c     <= OW'(r_mis[1]);
                    r_res.mismatch_g     <= OW'(r_mis[2]);
                    r_res.mismatch_t     <= OW'(r_mis[3]);
                    r_res.inserted_total <= OW'(r_ins);
                    r_res.deleted_total  <= OW'(r_del);
                    r_res.starts_total   <= OW'(r_starts);
                    r_res.ends_total     <= OW'(r_ends);
                    r_res.mismatch_sum   <= ppc_pkg::SUM_WIDTH'(w_msum);
                    r_msum               <= w_msum;
                    r_fwd_snap           <= r_fwd;
                    r_den                <= (CW+1)'(r_fwd) + (CW+1)'(r_rev);
                    r_depth              <= i_cmd.depth;
                end
            end
            E_PREP: begin
                r_lhs  <= LW'(r_msum) * LW'(ppc_pkg::PCT_SCALE);
                r_rhs  <= LW'(i_min_pct) * LW'(r_depth);
                r_rem  <= DW'(r_fwd_snap) * DW'(ppc_pkg::PCT_SCALE);
                r_dsh  <= DW'(r_den) << (PW - 1);
                r_quo  <= '0;
                r_step <= SPW'(PW - 1);
            end
            E_DIV: begin
                if (w_fit) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_quo  <= w_quo;
                r_step <= r_step - 1'b1;
                if (r_step == '0) begin
                    r_res.forward_percent <= (r_den == '0) ? '0 : w_quo;
                    r_res.report_flag     <= (r_depth != '0) && (r_lhs >= r_rhs);
                end
            end
            E_OUT: begin
            end
            default: begin
            end
        endcase
    end

    assign o_out.valid   = (r_state == E_OUT);
    assign o_out.payload = r_res;

endmodule

### rtl/ppc_checker.sv
module ppc_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input ppc_pkg::t_out_item            i_out_payload
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // a stalled result does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_payload))
        else $error("result changed while stalled");

    // only one result in flight: a taken result is not followed at once
    a_out_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready |=> !i_out_valid)
        else $error("back-to-back results from the end unit");

    // the divide never runs past full scale
    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_payload.forward_percent <= ppc_pkg::PCT_WIDTH'(ppc_pkg::PCT_SCALE))
        else $error("forward percentage above full scale");

endmodule

bind pileup_position_counter ppc_checker u_ppc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);

### verif/pileup_position_counter_tb.sv
module pileup_position_counter_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ppc_pkg::*;

    localparam int          SETTLE_CYCLES = 12;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_WIDTH) - 1;

    // mismatch counter slots
    localparam int SLOT_A = 0;
    localparam int SLOT_C = 1;
    localparam int SLOT_G = 2;
    localparam int SLOT_T = 3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [PCT_WIDTH-1:0] i_cfg_data;

    ppc_chan_if #(.t_payload(t_in_item))  in_ch ();
    ppc_chan_if #(.t_payload(t_out_item)) out_ch ();

    pileup_position_counter dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // predicted counter state for the current position
    logic [COUNT_WIDTH-1:0] match_cnt;
    logic [COUNT_WIDTH-1:0] mis_cnt [4];
    logic [COUNT_WIDTH-1:0] ins_sum;
    logic [COUNT_WIDTH-1:0] del_sum;
    logic [COUNT_WIDTH-1:0] fwd_cnt;
    logic [COUNT_WIDTH-1:0] rev_cnt;
    logic [COUNT_WIDTH-1:0] start_cnt;
    logic [COUNT_WIDTH-1:0] end_cnt;
    logic [PCT_WIDTH-1:0]   threshold;

    t_in_item  pending_requests [$];
    t_out_item position_results [$];

    int unsigned pushed_count   = 0;
    int unsigned accepted_count = 0;
    int unsigned error_count    = 0;
    int unsigned quiet_cycles   = 0;
    int unsigned drv_gap        = 0;
    int unsigned drv_calm       = 0;
    int unsigned mon_stall      = 0;
    int unsigned mon_calm       = 0;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [COUNT_WIDTH-1:0] sat_add(input logic [COUNT_WIDTH-1:0] acc,
                                                       input longint unsigned inc);
        longint unsigned s;
        s = acc;
        s += inc;
        if (s > COUNT_LIMIT) begin
            return COUNT_LIMIT[COUNT_WIDTH-1:0];
        end
        return s[COUNT_WIDTH-1:0];
    endfunction

    task automatic clear_tally();
        match_cnt = '0;
        for (int i = 0; i < 4; i++) begin
            mis_cnt[i] = '0;
        end
        ins_sum   = '0;
        del_sum   = '0;
        fwd_cnt   = '0;
        rev_cnt   = '0;
        start_cnt = '0;
        end_cnt   = '0;
    endtask

    // update the predicted counters with one accepted request; an end predicts a result
    task automatic tally_request(input t_in_item it);
        t_out_item       res;
        longint unsigned mis_total;
        longint unsigned strands;
        longint unsigned pct;
        longint unsigned thr_depth;
        accepted_count++;
        if (it.kind == KIND_END) begin
            mis_total = mis_cnt[SLOT_A];
            mis_total += mis_cnt[SLOT_C];
            mis_total += mis_cnt[SLOT_G];
            mis_total += mis_cnt[SLOT_T];
            strands = fwd_cnt;
            strands += rev_cnt;
            pct = 0;
            if (strands > 0) begin
                pct = fwd_cnt;
                pct = (pct * PCT_SCALE) / strands;
            end
            thr_depth = threshold;
            thr_depth = thr_depth * it.depth;
            res.match_total     = match_cnt[OUT_WIDTH-1:0];
            res.mismatch_a      = mis_cnt[SLOT_A][OUT_WIDTH-1:0];
            res.mismatch_c      = mis_cnt[SLOT_C][OUT_WIDTH-1:0];
            res.mismatch_g      = mis_cnt[SLOT_G][OUT_WIDTH-1:0];
            res.mismatch_t      = mis_cnt[SLOT_T][OUT_WIDTH-1:0];
            res.inserted_total  = ins_sum[OUT_WIDTH-1:0];
            res.deleted_total   = del_sum[OUT_WIDTH-1:0];
            res.forward_percent = pct[PCT_WIDTH-1:0];
            res.starts_total    = start_cnt[OUT_WIDTH-1:0];
            res.ends_total      = end_cnt[OUT_WIDTH-1:0];
            res.mismatch_sum    = mis_total[SUM_WIDTH-1:0];
            res.report_flag     = (it.depth != '0) && (mis_total * PCT_SCALE >= thr_depth);
            position_results.push_back(res);
            clear_tally();
        end else if (!it.invalid) begin
            if (!it.skip) begin
                if (it.match) begin
                    match_cnt = sat_add(match_cnt, 1);
                end else begin
                    case (it.read_base)
                        BASE_A: mis_cnt[SLOT_A] = sat_add(mis_cnt[SLOT_A], 1);
                        BASE_C: mis_cnt[SLOT_C] = sat_add(mis_cnt[SLOT_C], 1);
                        BASE_G: mis_cnt[SLOT_G] = sat_add(mis_cnt[SLOT_G], 1);
                        BASE_T: mis_cnt[SLOT_T] = sat_add(mis_cnt[SLOT_T], 1);
                        default: ;
                    endcase
                end
            end
            if (it.on_reverse) begin
                rev_cnt = sat_add(rev_cnt, 1);
            end else begin
                fwd_cnt = sat_add(fwd_cnt, 1);
            end
            ins_sum = sat_add(ins_sum, it.inserted_count);
            del_sum = sat_add(del_sum, it.deleted_count);
            if (it.first_in_read) begin
                start_cnt = sat_add(start_cnt, 1);
            end
            if (it.last_in_read) begin
                end_cnt = sat_add(end_cnt, 1);
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
            error_count++;
        end
    endtask

    task automatic check_result(input t_out_item got);
        t_out_item want;
        if (position_results.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            error_count++;
        end else begin
            want = position_results.pop_front();
            compare_field("match_total", want.match_total, got.match_total);
            compare_field("mismatch_a", want.mismatch_a, got.mismatch_a);
            compare_field("mismatch_c", want.mismatch_c, got.mismatch_c);
            compare_field("mismatch_g", want.mismatch_g, got.mismatch_g);
            compare_field("mismatch_t", want.mismatch_t, got.mismatch_t);
            compare_field("inserted_total", want.inserted_total, got.inserted_total);
            compare_field("deleted_total", want.deleted_total, got.deleted_total);
            compare_field("forward_percent", want.forward_percent, got.forward_percent);
            compare_field("starts_total", want.starts_total, got.starts_total);
            compare_field("ends_total", want.ends_total, got.ends_total);
            compare_field("mismatch_sum", want.mismatch_sum, got.mismatch_sum);
            compare_field("report_flag", want.report_flag, got.report_flag);
        end
    endtask

    // mostly short gaps, a few long ones
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item place_item(input logic skip, input logic match,
                                            input logic [BASE_WIDTH-1:0] base,
                                            input logic rev, input logic [INC_WIDTH-1:0] ins,
                                            input logic [INC_WIDTH-1:0] del,
                                            input logic first, input logic last);
        t_in_item it;
        it                = '0;
        it.kind           = KIND_PLACE;
        it.skip           = skip;
        it.match          = match;
        it.read_base      = base;
        it.on_reverse     = rev;
        it.inserted_count = ins;
        it.deleted_count  = del;
        it.first_in_read  = first;
        it.last_in_read   = last;
        it.depth          = DEPTH_WIDTH'($urandom);
        return it;
    endfunction

    // end of position with random placement fields
    function automatic t_in_item end_item(input logic [DEPTH_WIDTH-1:0] depth);
        t_in_item    it;
        logic [95:0] noise;
        noise    = {$urandom, $urandom, $urandom};
        it       = noise[$bits(t_in_item)-1:0];
        it.kind  = KIND_END;
        it.depth = depth;
        return it;
    endfunction

    function automatic t_in_item rand_place();
        t_in_item    it;
        logic [95:0] noise;
        int unsigned r;
        noise      = {$urandom, $urandom, $urandom};
        it         = noise[$bits(t_in_item)-1:0];
        it.kind    = KIND_PLACE;
        it.invalid = ($urandom_range(0, 99) < 8);
        it.skip    = ($urandom_range(0, 99) < 10);
        it.match   = ($urandom_range(0, 99) < 45);
        if ($urandom_range(0, 99) < 75) begin
            case ($urandom_range(0, 3))
                0: it.read_base = BASE_A;
                1: it.read_base = BASE_C;
                2: it.read_base = BASE_G;
                default: it.read_base = BASE_T;
            endcase
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            it.inserted_count = '0;
        end else if (r < 85) begin
            it.inserted_count = INC_WIDTH'($urandom_range(1, 8));
        end else if (r >= 95) begin
            it.inserted_count = '1;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            it.deleted_count = '0;
        end else if (r < 85) begin
            it.deleted_count = INC_WIDTH'($urandom_range(1, 8));
        end else if (r >= 95) begin
            it.deleted_count = '1;
        end
        it.first_in_read = ($urandom_range(0, 99) < 25);
        it.last_in_read  = ($urandom_range(0, 99) < 25);
        return it;
    endfunction

    task automatic queue_request(input t_in_item it);
        pending_requests.push_back(it);
        pushed_count++;
    endtask

    // positions of random length, each closed by an end request
    task automatic queue_random_positions(input int unsigned n_items);
        int unsigned            placed;
        int unsigned            n;
        int unsigned            r;
        t_in_item               it;
        logic [DEPTH_WIDTH-1:0] depth;
        placed = 0;
        while (placed < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 10) begin
                n = 0;
            end else if (r < 85) begin
                n = $urandom_range(1, 10);
            end else begin
                n = $urandom_range(11, 30);
            end
            for (int k = 0; k < n; k++) begin
                it = rand_place();
                queue_request(it);
                if (!it.invalid) begin
                    placed++;
                end
            end
            r = $urandom_range(0, 99);
            if (r < 10) begin
                depth = '0;
            end else if (r < 20) begin
                depth = '1;
            end else if (r < 30) begin
                depth = DEPTH_WIDTH'($urandom);
            end else begin
                depth = DEPTH_WIDTH'($urandom_range(1, 4 * n + 4));
            end
            queue_request(end_item(depth));
            placed++;
        end
    endtask

    // hold the sender until every request is taken and every result is back
    task automatic drain_and_settle();
        while (accepted_count != pushed_count) begin
            @(posedge i_clk);
        end
        while (position_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_threshold(input logic [PCT_WIDTH-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        threshold = value;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                tally_request(in_ch.payload);
            end
            if (drv_calm > 0) begin
                drv_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
                drv_calm = $urandom_range(30, 120);
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (drv_gap > 0) begin
                    drv_gap--;
                    in_ch.valid <= 1'b0;
                end else if (pending_requests.size() > 0) begin
                    in_ch.payload <= pending_requests.pop_front();
                    in_ch.valid   <= 1'b1;
                    drv_gap = (drv_calm > 0) ? 0 : pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                check_result(out_ch.payload);
            end
            if (mon_calm > 0) begin
                mon_calm--;
            end else if ($urandom_range(0, 99) < 2) begin
                mon_calm = $urandom_range(30, 120);
            end
            if (mon_stall > 0) begin
                mon_stall--;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                if (mon_calm == 0 && $urandom_range(0, 99) < 20) begin
                    mon_stall = pick_gap();
                end
            end
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    // stimulus
    initial begin
        t_in_item             it;
        logic [PCT_WIDTH-1:0] thr_plan [6];
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_data    = '0;
        in_ch.valid   = 1'b0;
        in_ch.payload = '0;
        out_ch.ready  = 1'b0;
        threshold     = '0;
        clear_tally();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty position, every base, ambiguous codes, skip, invalid, field extremes
        queue_request(end_item('0));
        queue_request(place_item(1'b0, 1'b1, BASE_A, 1'b0, '1, '0, 1'b1, 1'b0));
        queue_request(place_item(1'b0, 1'b0, BASE_A, 1'b1, '0, '1, 1'b0, 1'b0));
        queue_request(place_item(1'b0, 1'b0, BASE_C, 1'b0, '0, '0, 1'b0, 1'b1));
        queue_request(place_item(1'b0, 1'b0, BASE_G, 1'b1, 16'd3, 16'd2, 1'b0, 1'b0));
        queue_request(place_item(1'b0, 1'b0, BASE_T, 1'b1, '0, '0, 1'b0, 1'b0));
        queue_request(place_item(1'b0, 1'b0, 4'hF, 1'b0, '0, '0, 1'b0, 1'b0));
        queue_request(place_item(1'b0, 1'b0, 4'h0, 1'b0, '0, '0, 1'b0, 1'b0));
        queue_request(place_item(1'b1, 1'b0, BASE_A, 1'b1, 16'd1, 16'd1, 1'b1, 1'b1));
        it      = '1;
        it.kind = KIND_PLACE;
        queue_request(it);
        it       = place_item(1'b0, 1'b1, BASE_T, 1'b0, 16'd1, 16'd1, 1'b0, 1'b0);
        it.depth = '1;
        queue_request(it);
        queue_request(end_item('1));
        queue_request(place_item(1'b0, 1'b1, BASE_C, 1'b1, '0, '0, 1'b0, 1'b0));
        it       = '1;
        it.kind  = KIND_END;
        it.depth = 24'd1;
        queue_request(it);
        drain_and_settle();

        // threshold above 100, flag on both sides of the boundary, zero depth
        write_threshold(7'd127);
        queue_request(place_item(1'b0, 1'b0, BASE_A, 1'b0, '0, '0, 1'b0, 1'b0));
        queue_request(place_item(1'b0, 1'b0, BASE_C, 1'b1, '0, '0, 1'b0, 1'b0));
        queue_request(end_item(24'd1));
        queue_request(place_item(1'b0, 1'b0, BASE_A, 1'b0, '0, '0, 1'b0, 1'b0));
        queue_request(end_item(24'd1));
        queue_request(place_item(1'b0, 1'b0, BASE_G, 1'b0, '0, '0, 1'b0, 1'b0));
        queue_request(end_item('0));
        drain_and_settle();

        // random phases, each under its own threshold
        thr_plan = '{7'd100, 7'd1, 7'd127, 7'd0, PCT_WIDTH'($urandom_range(2, 99)),
                     PCT_WIDTH'($urandom_range(101, 126))};
        for (int p = 0; p < 6; p++) begin
            write_threshold(thr_plan[p]);
            if (p == 4) begin
                // one long position that drives the indel sums into saturation
                for (int k = 0; k < 270; k++) begin
                    it                = rand_place();
                    it.invalid        = 1'b0;
                    it.inserted_count = '1;
                    it.deleted_count  = INC_WIDTH'(16'hFFFF - $urandom_range(0, 1));
                    queue_request(it);
                end
                queue_request(end_item(DEPTH_WIDTH'($urandom_range(1, 1000))));
                queue_random_positions(40);
            end else begin
                queue_random_positions(75);
            end
            drain_and_settle();
        end

        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
